[hdl/infix_four_op_evaluator_top_defines.svh]
// assertion macros used by the checker file
`ifndef INFIX_FOUR_OP_EVALUATOR_TOP_DEFINES_SVH
`define INFIX_FOUR_OP_EVALUATOR_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define IFOE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IFOE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ifoe_pkg.sv]
package ifoe_pkg;

    // widths
    localparam int unsigned VALUE_WIDTH_DEF = 32;
    localparam int unsigned CHAR_WIDTH      = 8;
    localparam int unsigned OUT_WIDTH       = 32;

    // character codes
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_TIMES = 8'h2A;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;

    // pending operator
    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } t_op;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_ITER,
        ST_FINISH,
        ST_SUM
    } t_state;

    // datapath commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CHAR,
        CMD_APPLY,
        CMD_STEP,
        CMD_FINISH,
        CMD_SUM
    } t_cmd;

    // datapath status seen by the controller
    typedef struct packed {
        logic closing;
        logic last;
        t_op  op;
        logic div_zero;
    } t_dp_status;

    function automatic logic f_is_digit(input logic [CHAR_WIDTH-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic f_is_space(input logic [CHAR_WIDTH-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // anything that is not + - * counts as divide
    function automatic t_op f_op_of(input logic [CHAR_WIDTH-1:0] c);
        t_op op;
        if (c == CH_PLUS) begin
            op = OP_PLUS;
        end else if (c == CH_MINUS) begin
            op = OP_MINUS;
        end else if (c == CH_TIMES) begin
            op = OP_TIMES;
        end else begin
            op = OP_DIVIDE;
        end
        return op;
    endfunction

endpackage

[hdl/ifoe_if.sv]
// character channel
interface ifoe_char_if;
    logic                              valid;
    logic                              ready;
    logic [ifoe_pkg::CHAR_WIDTH-1:0]   char_code;
    logic                              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// result channel
interface ifoe_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [ifoe_pkg::OUT_WIDTH-1:0] value;
    logic                                div_by_zero;

    modport source (output valid, output value, output div_by_zero, input ready);
    modport sink (input valid, input value, input div_by_zero, output ready);
endinterface

[hdl/ifoe_ctrl.sv]
module ifoe_ctrl #(
    parameter int unsigned VALUE_WIDTH = ifoe_pkg::VALUE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  ifoe_pkg::t_dp_status i_status,
    output ifoe_pkg::t_cmd       o_cmd
);

    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

    ifoe_pkg::t_state r_state;
    ifoe_pkg::t_state n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             iter_needed;
    logic             out_free;
    logic             load_out;

    // multiply always iterates, divide only with a nonzero divisor
    assign iter_needed = (i_status.op == ifoe_pkg::OP_TIMES) ||
                         ((i_status.op == ifoe_pkg::OP_DIVIDE) && !i_status.div_zero);
    assign out_free    = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ifoe_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.closing) begin
                    n_state = ifoe_pkg::ST_APPLY;
                end
            end
            ifoe_pkg::ST_APPLY: begin
                if (iter_needed) begin
                    n_state = ifoe_pkg::ST_ITER;
                end else if (i_status.last) begin
                    n_state = ifoe_pkg::ST_SUM;
                end else begin
                    n_state = ifoe_pkg::ST_IDLE;
                end
            end
            ifoe_pkg::ST_ITER: begin
                if (r_cnt == '0) begin
                    n_state = ifoe_pkg::ST_FINISH;
                end
            end
            ifoe_pkg::ST_FINISH: begin
                n_state = i_status.last ? ifoe_pkg::ST_SUM : ifoe_pkg::ST_IDLE;
            end
            ifoe_pkg::ST_SUM: begin
                if (out_free) begin
                    n_state = ifoe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ifoe_pkg::ST_IDLE;
            end
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        o_cmd      = ifoe_pkg::CMD_NONE;
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        n_cnt      = r_cnt;
        case (r_state)
            ifoe_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = ifoe_pkg::CMD_CHAR;
                end
            end
            ifoe_pkg::ST_APPLY: begin
                o_cmd = ifoe_pkg::CMD_APPLY;
                n_cnt = CNT_W'(VALUE_WIDTH - 1);
            end
            ifoe_pkg::ST_ITER: begin
                o_cmd = ifoe_pkg::CMD_STEP;
                n_cnt = r_cnt - 1'b1;
            end
            ifoe_pkg::ST_FINISH: begin
                o_cmd = ifoe_pkg::CMD_FINISH;
            end
            ifoe_pkg::ST_SUM: begin
                if (out_free) begin
                    o_cmd    = ifoe_pkg::CMD_SUM;
                    load_out = 1'b1;
                end
            end
            default: begin
                o_cmd = ifoe_pkg::CMD_NONE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ifoe_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hdl/ifoe_dpath.sv]
module ifoe_dpath #(
    parameter int unsigned VALUE_WIDTH = ifoe_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ifoe_pkg::t_cmd                        i_cmd,
    input  logic [ifoe_pkg::CHAR_WIDTH-1:0]       i_char_code,
    input  logic                                  i_last_char,
    output ifoe_pkg::t_dp_status                  o_status,
    output logic signed [ifoe_pkg::OUT_WIDTH-1:0] o_value,
    output logic                                  o_div_by_zero
);

    localparam int unsigned W = VALUE_WIDTH;

    // expression state
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_term;
    logic [W-1:0]  r_total;
    ifoe_pkg::t_op r_op;
    logic          r_err;
    // closing character info
    logic          r_last;
    ifoe_pkg::t_op r_newop;
    // shared shift-add / shift-subtract unit
    logic [W-1:0]  r_opa;
    logic [W-1:0]  r_opb;
    logic [W-1:0]  r_work;
    logic          r_neg;
    // result register
    logic signed [ifoe_pkg::OUT_WIDTH-1:0] r_value;
    logic                                  r_dbz;

    logic          is_digit;
    logic          is_space;
    logic [W-1:0]  acc_x10;
    logic [W-1:0]  mag_term;
    logic [W-1:0]  mag_acc;
    logic [W:0]    rem_shift;
    logic [W:0]    rem_diff;
    logic [W-1:0]  quot;
    logic [W-1:0]  sum;
    logic [63:0]   sum_ext;

    assign is_digit = ifoe_pkg::f_is_digit(i_char_code);
    assign is_space = ifoe_pkg::f_is_space(i_char_code);

    // decimal accumulate: acc * 10 + digit
    assign acc_x10 = (r_acc << 3) + (r_acc << 1) + W'(i_char_code[3:0]);

    // operand magnitudes for the divider
    assign mag_term = r_term[W-1] ? (W'(0) - r_term) : r_term;
    assign mag_acc  = r_acc[W-1] ? (W'(0) - r_acc) : r_acc;

    // one restoring division step
    assign rem_shift = {r_work, r_opa[W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_opb};
    assign quot      = r_neg ? (W'(0) - r_opa) : r_opa;

    // final sum, low bits zero extended to the output width
    assign sum     = r_total + r_term;
    assign sum_ext = 64'(sum);

    assign o_status.closing  = (!is_digit && !is_space) || i_last_char;
    assign o_status.last     = r_last;
    assign o_status.op       = r_op;
    assign o_status.div_zero = (r_acc == '0);

    assign o_value       = r_value;
    assign o_div_by_zero = r_dbz;

    // expression state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_term  <= '0;
            r_total <= '0;
            r_op    <= ifoe_pkg::OP_PLUS;
            r_err   <= 1'b0;
        end else begin
            case (i_cmd)
                ifoe_pkg::CMD_CHAR: begin
                    if (is_digit) begin
                        r_acc <= acc_x10;
                    end
                end
                ifoe_pkg::CMD_APPLY: begin
                    case (r_op)
                        ifoe_pkg::OP_PLUS: begin
                            r_total <= sum;
                            r_term  <= r_acc;
                            r_acc   <= '0;
                            r_op    <= r_newop;
                        end
                        ifoe_pkg::OP_MINUS: begin
                            r_total <= sum;
                            r_term  <= W'(0) - r_acc;
                            r_acc   <= '0;
                            r_op    <= r_newop;
                        end
                        ifoe_pkg::OP_TIMES: begin
                            r_acc <= r_acc;
                        end
                        default: begin
                            // divide by zero leaves the term alone
                            if (r_acc == '0) begin
                                r_err <= 1'b1;
                                r_op  <= r_newop;
                            end
                        end
                    endcase
                end
                ifoe_pkg::CMD_FINISH: begin
                    r_term <= (r_op == ifoe_pkg::OP_TIMES) ? r_work : quot;
                    r_acc  <= '0;
                    r_op   <= r_newop;
                end
                ifoe_pkg::CMD_SUM: begin
                    r_acc   <= '0;
                    r_term  <= '0;
                    r_total <= '0;
                    r_op    <= ifoe_pkg::OP_PLUS;
                    r_err   <= 1'b0;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    // closing info, iteration unit and result register
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            ifoe_pkg::CMD_CHAR: begin
                r_last  <= i_last_char;
                r_newop <= ifoe_pkg::f_op_of(i_char_code);
            end
            ifoe_pkg::CMD_APPLY: begin
                r_work <= '0;
                if (r_op == ifoe_pkg::OP_TIMES) begin
                    r_opa <= r_term;
                    r_opb <= r_acc;
                end else begin
                    r_opa <= mag_term;
                    r_opb <= mag_acc;
                end
                r_neg <= r_term[W-1] ^ r_acc[W-1];
            end
            ifoe_pkg::CMD_STEP: begin
                if (r_op == ifoe_pkg::OP_TIMES) begin
                    // shift-add multiply, low bits only
                    if (r_opb[0]) begin
                        r_work <= r_work + r_opa;
                    end
                    r_opa <= r_opa << 1;
                    r_opb <= r_opb >> 1;
                end else if (!rem_diff[W]) begin
                    r_work <= rem_diff[W-1:0];
                    r_opa  <= {r_opa[W-2:0], 1'b1};
                end else begin
                    r_work <= rem_shift[W-1:0];
                    r_opa  <= {r_opa[W-2:0], 1'b0};
                end
            end
            ifoe_pkg::CMD_SUM: begin
                r_value <= sum_ext[ifoe_pkg::OUT_WIDTH-1:0];
                r_dbz   <= r_err;
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

endmodule

[hdl/infix_four_op_evaluator_top.sv]
// infix expression evaluator: + - * / with the usual precedence
// i_char takes one ascii character per transaction; last_char marks the end
// of an expression. digits build a number, spaces are skipped, and any other
// character that is not + - * is taken as divide.
// o_result gives one transaction per expression: the value, wrapped to
// VALUE_WIDTH bits, and a flag set if any division by zero happened.
// a digit or space is taken while idle; a character closing a number goes through apply,
// and * or / by a nonzero divisor then iterates in the one-bit-per-cycle shift-add /
// shift-subtract unit and finishes; the last character adds a sum state for the result.
// one character is in work at a time; i_char.ready is high only while idle.
// the result waits in an output register, so characters of the next
// expression are taken while it is unclaimed; only the next end of
// expression waits for o_result.ready.
// reset (synchronous, active low) clears the expression state and drops
// o_result.valid; no clearing pass is needed.
module infix_four_op_evaluator_top #(
    parameter int unsigned VALUE_WIDTH = ifoe_pkg::VALUE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ifoe_char_if.sink    i_char,
    ifoe_result_if.source o_result
);

    ifoe_pkg::t_cmd       cmd;
    ifoe_pkg::t_dp_status status;

    // sequencer
    ifoe_ctrl #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_char.valid),
        .o_in_ready  (i_char.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic and expression state
    ifoe_dpath #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_char_code   (i_char.char_code),
        .i_last_char   (i_char.last_char),
        .o_status      (status),
        .o_value       (o_result.value),
        .o_div_by_zero (o_result.div_by_zero)
    );

endmodule

[hdl/ifoe_checker.sv]
`include "infix_four_op_evaluator_top_defines.svh"

module ifoe_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic [ifoe_pkg::CHAR_WIDTH-1:0]     i_char_code,
    input logic                                i_last_char,
    input logic                                i_out_valid,
    input logic                                i_out_ready
);

    logic in_acc;
    logic digit_mid;

    assign in_acc    = i_in_valid && i_in_ready;
    assign digit_mid = in_acc && !i_last_char &&
                       (i_char_code >= ifoe_pkg::CH_ZERO) &&
                       (i_char_code <= ifoe_pkg::CH_NINE);

    // a pending result is not dropped while stalled
    `IFOE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    // a character inside an expression never produces a result
    `IFOE_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, in_acc && !i_last_char, !$rose(i_out_valid), "result without end of expression")
    // a digit inside an expression leaves the block ready in the next cycle
    `IFOE_ASSERT_NEXT(a_digit_one_cycle, i_clk, i_rst_n, digit_mid, i_in_ready, "digit did not finish in one cycle")
    // end of expression keeps the block busy while the result is formed
    `IFOE_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, in_acc && i_last_char, !i_in_ready, "input taken while result is formed")

endmodule

bind infix_four_op_evaluator_top ifoe_checker u_ifoe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_char.valid),
    .i_in_ready  (i_char.ready),
    .i_char_code (i_char.char_code),
    .i_last_char (i_char.last_char),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);

[tb/infix_four_op_evaluator_top_tb.sv]
`timescale 1ns / 1ps

module infix_four_op_evaluator_top_tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int DECIMAL_BASE = 10;

    // characters the package does not name
    localparam logic [ifoe_pkg::CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;

    typedef logic [ifoe_pkg::CHAR_WIDTH-1:0] t_char;

    typedef struct packed {
        logic signed [ifoe_pkg::OUT_WIDTH-1:0] value;
        logic                                  div_by_zero;
    } t_expr_result;

    logic i_clk;
    logic i_rst_n;

    ifoe_char_if   char_ch();
    ifoe_result_if result_ch();

    infix_four_op_evaluator_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_ch),
        .o_result (result_ch)
    );

    // expression state of the predictor
    ifoe_pkg::t_op pend_op;
    logic [31:0]   number;
    logic [31:0]   term;
    logic [31:0]   total;
    logic          zero_div;

    t_expr_result expr_results_due[$];
    t_char        expr_text[$];

    int fail_count   = 0;
    int report_count = 0;
    int sent_chars   = 0;
    int idle_cycles  = 0;
    bit gaps_on      = 1'b1;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 10);
        else return $urandom_range(20, 60);
    endfunction

    function automatic logic char_is_digit(t_char c);
        return (c >= ifoe_pkg::CH_ZERO) && (c <= ifoe_pkg::CH_NINE);
    endfunction

    function automatic logic char_is_space(t_char c);
        return (c == ifoe_pkg::CH_SPACE) ||
               ((c >= ifoe_pkg::CH_TAB) && (c <= ifoe_pkg::CH_CR));
    endfunction

    function automatic logic [31:0] magnitude_of(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    // append one character to the expression text
    function automatic void add_char(t_char c);
        expr_text = {expr_text, c};
    endfunction

    function automatic void clear_expression();
        pend_op  = ifoe_pkg::OP_PLUS;
        number   = '0;
        term     = '0;
        total    = '0;
        zero_div = 1'b0;
    endfunction

    // apply the pending operator to the number just closed
    function automatic void close_number();
        logic [31:0] quot;
        case (pend_op)
            ifoe_pkg::OP_PLUS: begin
                total = total + term;
                term  = number;
            end
            ifoe_pkg::OP_MINUS: begin
                total = total + term;
                term  = -number;
            end
            ifoe_pkg::OP_TIMES: begin
                term = term * number;
            end
            default: begin
                if (number == 0) begin
                    zero_div = 1'b1;
                end else begin
                    quot = magnitude_of(term) / magnitude_of(number);
                    term = (term[31] ^ number[31]) ? -quot : quot;
                end
            end
        endcase
    endfunction

    // one accepted character; queues the value due at the end of an expression
    function automatic void evaluate_char(t_char c, logic last);
        logic         is_digit;
        logic         is_space;
        t_expr_result res;
        is_digit = char_is_digit(c);
        is_space = char_is_space(c);
        if (is_digit) begin
            number = number * DECIMAL_BASE + 32'(c - ifoe_pkg::CH_ZERO);
        end
        if ((!is_digit && !is_space) || last) begin
            close_number();
            if (c == ifoe_pkg::CH_PLUS) pend_op = ifoe_pkg::OP_PLUS;
            else if (c == ifoe_pkg::CH_MINUS) pend_op = ifoe_pkg::OP_MINUS;
            else if (c == ifoe_pkg::CH_TIMES) pend_op = ifoe_pkg::OP_TIMES;
            else pend_op = ifoe_pkg::OP_DIVIDE;
            number = '0;
        end
        if (last) begin
            res.value       = total + term;
            res.div_by_zero = zero_div;
            expr_results_due = {expr_results_due, res};
            clear_expression();
        end
    endfunction

    // one character transaction, with a random gap ahead of it
    task automatic send_char(input t_char c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.last_char <= last;
        do @(posedge i_clk); while (!char_ch.ready);
        evaluate_char(c, last);
        sent_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(t_char'(s[i]), i == s.len() - 1);
        end
    endtask

    task automatic send_expr_text();
        for (int i = 0; i < expr_text.size(); i++) begin
            send_char(expr_text[i], i == expr_text.size() - 1);
        end
    endtask

    // decimal literal: mostly small, some full width, some past 32 bits
    function automatic string random_literal();
        longint unsigned v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 9);
            4, 5:       v = $urandom_range(0, 999);
            6, 7:       v = $urandom;
            8: begin
                case ($urandom_range(0, 4))
                    0:       v = 0;
                    1:       v = 1;
                    2:       v = 64'd2147483647;
                    3:       v = 64'd2147483648;
                    default: v = 64'd4294967295;
                endcase
            end
            default:    v = {$urandom, $urandom} % 64'd1000000000000;
        endcase
        return $sformatf("%0d", v);
    endfunction

    function automatic t_char random_operator();
        t_char c;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:      c = ifoe_pkg::CH_PLUS;
            5, 6, 7, 8, 9:      c = ifoe_pkg::CH_MINUS;
            10, 11, 12, 13, 14: c = ifoe_pkg::CH_TIMES;
            15, 16, 17, 18:     c = CH_SLASH;
            default: begin
                // any other character counts as divide
                do c = t_char'($urandom_range(0, 255));
                while (char_is_digit(c) || char_is_space(c) ||
                       c == ifoe_pkg::CH_PLUS || c == ifoe_pkg::CH_MINUS ||
                       c == ifoe_pkg::CH_TIMES);
            end
        endcase
        return c;
    endfunction

    function automatic t_char random_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? ifoe_pkg::CH_SPACE : t_char'(ifoe_pkg::CH_TAB + r);
    endfunction

    function automatic void append_literal();
        string s;
        s = random_literal();
        for (int i = 0; i < s.len(); i++) add_char(t_char'(s[i]));
    endfunction

    function automatic void maybe_space();
        if ($urandom_range(0, 6) == 0) add_char(random_space());
    endfunction

    // well-formed expression with random content and optional odd ends
    function automatic void build_expression();
        int terms;
        int tail;
        expr_text.delete();
        if ($urandom_range(0, 15) == 0) add_char(random_operator());
        terms = $urandom_range(1, 6);
        for (int t = 0; t < terms; t++) begin
            if (t != 0) begin
                maybe_space();
                add_char(random_operator());
                maybe_space();
            end
            append_literal();
        end
        tail = $urandom_range(0, 19);
        if (tail == 0) add_char(random_operator());
        else if (tail == 1) add_char(random_space());
    endfunction

    function automatic void build_noise();
        int len;
        expr_text.delete();
        len = $urandom_range(1, 12);
        repeat (len) add_char(t_char'($urandom_range(0, 255)));
    endfunction

    task automatic run_expressions(input int n_chars, input int noise_pct);
        int start;
        start = sent_chars;
        while (sent_chars - start < n_chars) begin
            if ($urandom_range(0, 99) < noise_pct) build_noise();
            else build_expression();
            send_expr_text();
        end
    endtask

    // leading minus, every operator, truncation toward zero
    task automatic test_operator_precedence();
        send_text("-8/3*5+9");
    endtask

    task automatic test_division_by_zero();
        send_text("9/0");
    endtask

    // codes 255 and 0 as divide, trailing operator, white space closing the expression
    task automatic test_odd_characters();
        send_char(t_char'(ifoe_pkg::CH_ZERO + 8), 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(t_char'(ifoe_pkg::CH_ZERO + 2), 1'b0);
        send_char(8'h00, 1'b1);
        send_text("6\t*7 ");
    endtask

    // most negative value divided by minus one
    task automatic test_wraparound();
        send_text("2147483648/4294967295");
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_expressions(200, 10);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_expressions();
        run_expressions(1100, 5);
    endtask

    task automatic test_noise();
        run_expressions(100, 100);
    endtask

    // result side: random stalls on ready
    initial begin
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                result_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // compare each result transaction with the oldest value due
    always @(posedge i_clk) begin
        t_expr_result due;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expr_results_due.size() == 0) begin
                fail_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("unexpected result: value %0d div_by_zero %0b",
                             result_ch.value, result_ch.div_by_zero);
                end
            end else begin
                due = expr_results_due.pop_front();
                if (result_ch.value !== due.value ||
                    result_ch.div_by_zero !== due.div_by_zero) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("mismatch: expected %0d / dbz %0b, got %0d / dbz %0b",
                                 due.value, due.div_by_zero,
                                 result_ch.value, result_ch.div_by_zero);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (char_ch.valid && char_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL infix_four_op_evaluator_top");
            $finish;
        end
    end

    // test sequence
    initial begin
        i_rst_n           <= 1'b0;
        char_ch.valid     <= 1'b0;
        char_ch.char_code <= '0;
        char_ch.last_char <= 1'b0;
        clear_expression();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_operator_precedence();
        test_division_by_zero();
        test_odd_characters();
        test_wraparound();
        test_back_to_back();
        test_random_expressions();
        test_noise();

        char_ch.valid <= 1'b0;
        while (expr_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expr_results_due.size() == 0) begin
            $display("PASS infix_four_op_evaluator_top");
        end else begin
            $display("FAIL infix_four_op_evaluator_top");
        end
        $finish;
    end

endmodule

[infix_four_op_evaluator_top.f]
+incdir+hdl
hdl/ifoe_pkg.sv
hdl/ifoe_if.sv
hdl/ifoe_ctrl.sv
hdl/ifoe_dpath.sv
hdl/infix_four_op_evaluator_top.sv
hdl/ifoe_checker.sv
tb/infix_four_op_evaluator_top_tb.sv
